### src/svdma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svdma_pkg
// Shared types and constants of the sprite and video DMA controller.
// ----------------------------------------------------------------------------
package svdma_pkg;

  localparam int SPRITE_BYTES = 160;
  localparam int BLOCK_TICKS  = 32;
  localparam int BURST_BYTES  = 16;
  localparam int QUEUE_DEPTH  = 4;

  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = QPTR_W + 1;
  localparam int POS_W  = $clog2(BURST_BYTES + 2);

  localparam logic [15:0] ADDR_SPRITE_DMA = 16'hFF46;
  localparam logic [15:0] ADDR_VSRC_HI    = 16'hFF51;
  localparam logic [15:0] ADDR_VSRC_LO    = 16'hFF52;
  localparam logic [15:0] ADDR_VDST_HI    = 16'hFF53;
  localparam logic [15:0] ADDR_VDST_LO    = 16'hFF54;
  localparam logic [15:0] ADDR_VCTRL      = 16'hFF55;
  localparam logic [15:0] ADDR_HRAM_LO    = 16'hFF80;
  localparam logic [15:0] ADDR_HRAM_HI    = 16'hFFFE;

  localparam logic [15:0] VSRC_MASK  = 16'hFFF0;
  localparam logic [12:0] VDST_MASK  = 13'h1FF0;
  localparam logic [11:0] VLEN_RESET = 12'h07F;
  localparam logic [11:0] VLEN_UNIT  = 12'h010;
  localparam logic [7:0]  BYTE_IDLE  = 8'hFF;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    VMODE_NONE    = 2'd0,
    VMODE_GENERAL = 2'd1,
    VMODE_HBLANK  = 2'd2
  } vmode_t;

  typedef struct packed {
    logic [7:0]  rd;
    logic        claimed;
    logic        blocked;
    logic        spr_v;
    logic [15:0] spr_src;
    logic [7:0]  spr_dst;
    logic        vid_v;
    logic [15:0] vid_src;
    logic [12:0] vid_dst;
    vmode_t      mode;
  } job_t;

endpackage

### src/sprite_and_video_dma_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_and_video_dma_controller
// Sprite table DMA and video DMA controller: register access, machine ticks
// and byte copy requests.
// ----------------------------------------------------------------------------
// channel   direction  handshake            payload
// in_*      input      in_valid / in_stall  command, address, data, tick flags
// out_*     output     out_valid/out_stall  read data, status, copy request
// cfg_*     input      cfg_we               color mode bit
//
// the front takes one transaction per cycle whenever the job queue has room
// a read, write or idle tick gives one result via the job queue and output register
// a tick with a video burst gives 16 or 17 results, one per cycle while out_stall
// is low, from the back expander; the 4-entry job queue absorbs the difference
// reset is synchronous and restores the control and state registers, not the
// queue slots or output data; no clearing pass. out_stall holds the output
// register and, once the queue fills, raises in_stall
module sprite_and_video_dma_controller import svdma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_command,
  input  logic [15:0] in_bus_address,
  input  logic [7:0]  in_write_byte,
  input  logic        in_fast_clock,
  input  logic        in_video_step_allowed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_byte,
  output logic        out_claimed,
  output logic        out_blocked,
  output logic        out_copy_valid,
  output logic        out_copy_target,
  output logic [15:0] out_copy_source,
  output logic [12:0] out_copy_dest,
  output logic [1:0]  out_video_mode,
  output logic        out_last
);

  job_t job, head;
  logic accept, empty, full, pop;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  svdma_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata),
    .accept             (accept),
    .command            (in_command),
    .bus_address        (in_bus_address),
    .write_byte         (in_write_byte),
    .fast_clock         (in_fast_clock),
    .video_step_allowed (in_video_step_allowed),
    .job                (job)
  );

  svdma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (job),
    .pop       (pop),
    .head      (head),
    .empty     (empty),
    .full      (full)
  );

  svdma_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .empty           (empty),
    .pop             (pop),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_read_byte   (out_read_byte),
    .out_claimed     (out_claimed),
    .out_blocked     (out_blocked),
    .out_copy_valid  (out_copy_valid),
    .out_copy_target (out_copy_target),
    .out_copy_source (out_copy_source),
    .out_copy_dest   (out_copy_dest),
    .out_video_mode  (out_video_mode),
    .out_last        (out_last)
  );

endmodule

### src/svdma_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svdma_front
// Register file and DMA state; turns each transaction into one job.
// ----------------------------------------------------------------------------
module svdma_front import svdma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        accept,
  input  logic [1:0]  command,
  input  logic [15:0] bus_address,
  input  logic [7:0]  write_byte,
  input  logic        fast_clock,
  input  logic        video_step_allowed,
  output job_t        job
);

  logic        color_mode_r;
  logic [7:0]  page_r, page_nxt;
  logic        active_r, active_nxt;
  logic        restart_r, restart_nxt;
  logic [1:0]  delay_r, delay_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [15:0] ssrc_r, ssrc_nxt;
  logic [15:0] vsrc_reg_r, vsrc_reg_nxt;
  logic [15:0] vdst_reg_r, vdst_reg_nxt;
  logic [15:0] vsrc_ptr_r, vsrc_ptr_nxt;
  logic [12:0] vdst_ptr_r, vdst_ptr_nxt;
  logic [11:0] vlen_r, vlen_nxt;
  vmode_t      vstate_r, vstate_nxt;
  logic [6:0]  vticks_r, vticks_nxt;

  cmd_t        cmd;
  logic        is_claimed;
  logic        is_blocked;
  logic [6:0]  vtick_sum;
  logic [7:0]  cnt_inc;
  logic [11:0] vlen_m1;

  assign cmd        = cmd_t'(command);
  assign is_claimed = (bus_address == ADDR_SPRITE_DMA) ||
                      (bus_address >= ADDR_VSRC_HI && bus_address <= ADDR_VCTRL);
  assign is_blocked = (bus_address != ADDR_SPRITE_DMA) && active_r &&
                      (bus_address < ADDR_HRAM_LO || bus_address > ADDR_HRAM_HI);
  assign vtick_sum  = vticks_r + (fast_clock ? 7'd2 : 7'd4);
  assign cnt_inc    = count_r + 8'd1;
  assign vlen_m1    = vlen_r - 12'd1;

  always_comb begin
    page_nxt     = page_r;
    active_nxt   = active_r;
    restart_nxt  = restart_r;
    delay_nxt    = delay_r;
    count_nxt    = count_r;
    ssrc_nxt     = ssrc_r;
    vsrc_reg_nxt = vsrc_reg_r;
    vdst_reg_nxt = vdst_reg_r;
    vsrc_ptr_nxt = vsrc_ptr_r;
    vdst_ptr_nxt = vdst_ptr_r;
    vlen_nxt     = vlen_r;
    vstate_nxt   = vstate_r;
    vticks_nxt   = vticks_r;
    job          = '0;
    job.rd       = BYTE_IDLE;
    if (accept) begin
      unique case (cmd)
        CMD_WRITE: begin
          job.claimed = is_claimed;
          job.blocked = is_blocked;
          if (bus_address == ADDR_SPRITE_DMA) begin
            page_nxt = write_byte;
            if (active_r) begin
              restart_nxt = 1'b1;
            end else begin
              active_nxt  = 1'b1;
              count_nxt   = '0;
              ssrc_nxt    = {write_byte, 8'h00};
              delay_nxt   = restart_r ? 2'd1 : 2'd2;
              restart_nxt = 1'b0;
            end
          end else if (!is_blocked) begin
            if (bus_address == ADDR_VSRC_HI) begin
              vsrc_reg_nxt[15:8] = write_byte;
            end else if (bus_address == ADDR_VSRC_LO) begin
              vsrc_reg_nxt[7:0] = write_byte;
            end else if (bus_address == ADDR_VDST_HI) begin
              vdst_reg_nxt[15:8] = write_byte;
            end else if (bus_address == ADDR_VDST_LO) begin
              vdst_reg_nxt[7:0] = write_byte;
            end else if (bus_address == ADDR_VCTRL && color_mode_r) begin
              if (vstate_r != VMODE_NONE) begin
                if (!write_byte[7]) vstate_nxt = VMODE_NONE;
              end else begin
                vsrc_ptr_nxt = vsrc_reg_r & VSRC_MASK;
                vdst_ptr_nxt = vdst_reg_r[12:0] & VDST_MASK;
                vlen_nxt     = 12'(({5'b0, write_byte[6:0]} + 12'd1) * VLEN_UNIT);
                vstate_nxt   = write_byte[7] ? VMODE_HBLANK : VMODE_GENERAL;
                vticks_nxt   = '0;
              end
            end
          end
        end
        CMD_READ: begin
          job.claimed = is_claimed;
          job.blocked = is_blocked;
          if (bus_address == ADDR_SPRITE_DMA) begin
            job.rd = page_r;
          end else if (!is_blocked && color_mode_r) begin
            if (bus_address == ADDR_VSRC_HI) job.rd = vsrc_reg_r[15:8];
            else if (bus_address == ADDR_VSRC_LO) job.rd = vsrc_reg_r[7:0];
            else if (bus_address == ADDR_VDST_HI) job.rd = vdst_reg_r[15:8];
            else if (bus_address == ADDR_VDST_LO) job.rd = vdst_reg_r[7:0];
            else if (bus_address == ADDR_VCTRL) begin
              job.rd = {vstate_r == VMODE_NONE, vlen_m1[10:4]};
            end
          end
        end
        CMD_TICK: begin
          if (active_r) begin
            if (delay_r != 2'd0) begin
              delay_nxt = delay_r - 2'd1;
            end else begin
              job.spr_v   = 1'b1;
              job.spr_src = ssrc_r;
              job.spr_dst = count_r;
              ssrc_nxt    = ssrc_r + 16'd1;
              count_nxt   = cnt_inc;
              if (restart_r) begin
                count_nxt   = '0;
                ssrc_nxt    = {page_r, 8'h00};
                delay_nxt   = 2'd1;
                restart_nxt = 1'b0;
              end else if (cnt_inc >= 8'(SPRITE_BYTES)) begin
                active_nxt = 1'b0;
              end
            end
          end
          if (video_step_allowed && vstate_r != VMODE_NONE) begin
            vticks_nxt = vtick_sum;
            if (vtick_sum >= 7'(BLOCK_TICKS)) begin
              vticks_nxt   = vtick_sum - 7'(BLOCK_TICKS);
              job.vid_v    = 1'b1;
              job.vid_src  = vsrc_ptr_r;
              job.vid_dst  = vdst_ptr_r;
              vsrc_ptr_nxt = vsrc_ptr_r + 16'(BURST_BYTES);
              vdst_ptr_nxt = vdst_ptr_r + 13'(BURST_BYTES);
              if (vlen_r <= 12'(BURST_BYTES)) begin
                vstate_nxt = VMODE_NONE;
                vlen_nxt   = VLEN_RESET;
              end else begin
                vlen_nxt = vlen_r - 12'(BURST_BYTES);
              end
            end
          end
        end
        CMD_NONE: begin
        end
      endcase
    end
    job.mode = vstate_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
      page_r       <= '0;
      active_r     <= 1'b0;
      restart_r    <= 1'b0;
      delay_r      <= '0;
      count_r      <= '0;
      ssrc_r       <= '0;
      vsrc_reg_r   <= '0;
      vdst_reg_r   <= '0;
      vsrc_ptr_r   <= '0;
      vdst_ptr_r   <= '0;
      vlen_r       <= VLEN_RESET;
      vstate_r     <= VMODE_NONE;
      vticks_r     <= '0;
    end else begin
      if (cfg_we) color_mode_r <= cfg_wdata;
      page_r     <= page_nxt;
      active_r   <= active_nxt;
      restart_r  <= restart_nxt;
      delay_r    <= delay_nxt;
      count_r    <= count_nxt;
      ssrc_r     <= ssrc_nxt;
      vsrc_reg_r <= vsrc_reg_nxt;
      vdst_reg_r <= vdst_reg_nxt;
      vsrc_ptr_r <= vsrc_ptr_nxt;
      vdst_ptr_r <= vdst_ptr_nxt;
      vlen_r     <= vlen_nxt;
      vstate_r   <= vstate_nxt;
      vticks_r   <= vticks_nxt;
    end
  end

endmodule

### src/svdma_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svdma_queue
// Small job queue between the front and the back.
// ----------------------------------------------------------------------------
module svdma_queue import svdma_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  job_t  push_data,
  input  logic  pop,
  output job_t  head,
  output logic  empty,
  output logic  full
);

  job_t              slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign empty = (cnt_r == '0);
  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

### src/svdma_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svdma_back
// Expands each job into its results and drives the output register.
// ----------------------------------------------------------------------------
module svdma_back import svdma_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  job_t        head,
  input  logic        empty,
  output logic        pop,
  input  logic        out_stall,
  output logic        out_valid,
  output logic [7:0]  out_read_byte,
  output logic        out_claimed,
  output logic        out_blocked,
  output logic        out_copy_valid,
  output logic        out_copy_target,
  output logic [15:0] out_copy_source,
  output logic [12:0] out_copy_dest,
  output logic [1:0]  out_video_mode,
  output logic        out_last
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       rd_r;
  logic             claimed_r, blocked_r, cv_r, tgt_r, last_r;
  logic [15:0]      src_r;
  logic [12:0]      dst_r;
  vmode_t           mode_r;

  logic             load;
  logic [POS_W-1:0] total;
  logic [POS_W-1:0] k;
  logic             is_last;
  logic             spr_slot;

  assign total    = POS_W'(head.spr_v) + (head.vid_v ? POS_W'(BURST_BYTES) : '0);
  assign is_last  = (total == '0) || (pos_r == total - 1'b1);
  assign spr_slot = head.spr_v && (pos_r == '0);
  assign k        = pos_r - POS_W'(head.spr_v);
  assign load     = !empty && (!valid_r || !out_stall);
  assign pop      = load && is_last;

  always_comb begin
    pos_nxt   = pos_r;
    valid_nxt = valid_r && out_stall;
    if (load) begin
      valid_nxt = 1'b1;
      pos_nxt   = is_last ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      valid_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      mode_r <= head.mode;
      last_r <= is_last;
      if (spr_slot) begin
        rd_r      <= BYTE_IDLE;
        claimed_r <= 1'b0;
        blocked_r <= 1'b0;
        cv_r      <= 1'b1;
        tgt_r     <= 1'b0;
        src_r     <= head.spr_src;
        dst_r     <= {5'b0, head.spr_dst};
      end else if (head.vid_v) begin
        rd_r      <= BYTE_IDLE;
        claimed_r <= 1'b0;
        blocked_r <= 1'b0;
        cv_r      <= 1'b1;
        tgt_r     <= 1'b1;
        src_r     <= head.vid_src + 16'(k);
        dst_r     <= head.vid_dst + 13'(k);
      end else begin
        rd_r      <= head.rd;
        claimed_r <= head.claimed;
        blocked_r <= head.blocked;
        cv_r      <= 1'b0;
        tgt_r     <= 1'b0;
        src_r     <= '0;
        dst_r     <= '0;
      end
    end
  end

  assign out_valid       = valid_r;
  assign out_read_byte   = rd_r;
  assign out_claimed     = claimed_r;
  assign out_blocked     = blocked_r;
  assign out_copy_valid  = cv_r;
  assign out_copy_target = tgt_r;
  assign out_copy_source = src_r;
  assign out_copy_dest   = dst_r;
  assign out_video_mode  = mode_r;
  assign out_last        = last_r;

endmodule

### src/svdma_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svdma_checker
// Port-level checks of the sprite and video DMA controller.
// ----------------------------------------------------------------------------
module svdma_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic        cfg_wdata,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_command,
  input logic [15:0] in_bus_address,
  input logic [7:0]  in_write_byte,
  input logic        in_fast_clock,
  input logic        in_video_step_allowed,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_read_byte,
  input logic        out_claimed,
  input logic        out_blocked,
  input logic        out_copy_valid,
  input logic        out_copy_target,
  input logic [15:0] out_copy_source,
  input logic [12:0] out_copy_dest,
  input logic [1:0]  out_video_mode,
  input logic        out_last
);

  // stalled transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_copy_source) &&
      $stable(out_copy_dest) && $stable(out_last))
    else $error("output changed while stalled");

  // non-copy result stands alone
  a_idle_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_copy_valid |-> out_last)
    else $error("non-copy result not marked last");

  // blocked access reads as idle byte and is not a copy
  a_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_blocked |-> out_read_byte == 8'hFF && !out_copy_valid)
    else $error("blocked access returned data");

  // video burst walks consecutive source addresses
  a_burst_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_copy_valid && out_copy_target && !out_last |=>
      !out_valid || (out_copy_valid && out_copy_target &&
      out_copy_source == $past(out_copy_source) + 16'd1))
    else $error("video burst out of sequence");

endmodule

bind sprite_and_video_dma_controller svdma_checker u_svdma_checker (.*);
